@@ rtl/core/cat_pkg.sv @@
// ----------------------------------------------------------------------------
// cat_pkg
// Types, constants and codes shared by the channel allocation table.
// ----------------------------------------------------------------------------
`default_nettype none

package cat_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int ADDR_BITS   = 64;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int RAM_W       = 2 * ADDR_BITS;

	typedef enum logic [2:0] {
		REQ_UPDATE = 3'd0,
		REQ_LOOKUP = 3'd1,
		REQ_DELETE = 3'd2,
		REQ_CLEAR  = 3'd3,
		REQ_SETASG = 3'd4,
		REQ_SELECT = 3'd5
	} req_code_t;

	typedef enum logic [3:0] {
		ST_UPDATED   = 4'd0,
		ST_INSERTED  = 4'd1,
		ST_DELETED   = 4'd2,
		ST_ASSIGNED  = 4'd3,
		ST_UNCHANGED = 4'd4,
		ST_HELD      = 4'd5,
		ST_NOTFOUND  = 4'd6,
		ST_NOTFREE   = 4'd7,
		ST_NONEFREE  = 4'd8,
		ST_FULL      = 4'd9,
		ST_CLEARED   = 4'd10,
		ST_FOUND     = 4'd11
	} status_t;

	typedef enum logic [1:0] {
		AS_ZERO  = 2'd0,
		AS_RAM   = 2'd1,
		AS_INPUT = 2'd2
	} addr_sel_t;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [7:0]  chan_id;
		logic        free_flag;
		logic        assign_flag;
		logic [63:0] src_addr;
		logic [63:0] dst_addr;
	} req_t;

	typedef struct packed {
		logic [3:0]  status;
		logic [7:0]  out_chan_id;
		logic        out_free;
		logic        out_assigned;
		logic [63:0] out_src_addr;
		logic [63:0] out_dst_addr;
	} rsp_t;

endpackage

`default_nettype wire

@@ rtl/core/cat_if.sv @@
// ----------------------------------------------------------------------------
// cat_if
// Valid/ready channels carrying request and response words.
// ----------------------------------------------------------------------------
`default_nettype none

interface cat_req_if;
	logic          valid;
	logic          ready;
	cat_pkg::req_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface cat_rsp_if;
	logic          valid;
	logic          ready;
	cat_pkg::rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/channel_allocation_table.sv @@
// ----------------------------------------------------------------------------
// channel_allocation_table
// Ordered table of radio channels, newest first, with lookup and assignment.
// ----------------------------------------------------------------------------
// One request is taken at a time. The accept edge matches the id against all
// slots, updates flags and order and starts the registered read of the
// address RAM. The next edge registers the response word, held until the
// sink takes it. A new request is refused until the response word has left.
// Link addresses live in a single-port RAM indexed by physical slot; ids,
// flags and a slot order list sit in flip-flops. No clearing pass follows
// reset.
`default_nettype none

module channel_allocation_table (
	input  wire logic clk,
	input  wire logic arst_n,
	cat_req_if.sink   req,
	cat_rsp_if.source rsp
);
	import cat_pkg::*;

	logic [IDX_W-1:0] ord_q [TABLE_DEPTH];
	logic [CNT_W-1:0] cnt_q;
	logic [7:0]       chan_q [TABLE_DEPTH];
	logic             free_q [TABLE_DEPTH];
	logic             asg_q  [TABLE_DEPTH];

	logic [IDX_W-1:0] ord_d [TABLE_DEPTH];
	logic [CNT_W-1:0] cnt_d;

	logic pend_s1, out_valid_q;
	rsp_t out_q;

	logic        acc;
	req_t        r;
	logic [ADDR_BITS-1:0] src_m, dst_m;

	logic [TABLE_DEPTH-1:0] id_hit, sel_hit;
	logic             id_found, sel_found;
	logic [IDX_W-1:0] id_pos, sel_pos, id_slot, sel_slot;

	logic             ram_we, ram_re;
	logic [IDX_W-1:0] ram_addr;
	logic [RAM_W-1:0] ram_wdata, ram_rdata;

	logic             f_we, f_free, f_asg, f_chan_we;
	logic [IDX_W-1:0] f_slot;

	status_t   st_d;
	addr_sel_t asel_d;
	logic      held_chk_d;
	logic [7:0] oc_d;
	logic      of_d, oa_d;

	status_t   st_s1;
	addr_sel_t asel_s1;
	logic      held_chk_s1;
	logic [7:0] oc_s1;
	logic      of_s1, oa_s1;
	logic [ADDR_BITS-1:0] src_s1, dst_s1;

	logic [ADDR_BITS-1:0] o_src, o_dst;
	status_t st_fin;

	assign req.ready = !pend_s1 && !out_valid_q;
	assign acc   = req.valid && req.ready;
	assign r     = req.data;
	assign src_m = r.src_addr[ADDR_BITS-1:0];
	assign dst_m = r.dst_addr[ADDR_BITS-1:0];

	// Match in logical order, lowest position wins
	always_comb begin
		id_found  = 1'b0;
		sel_found = 1'b0;
		id_pos    = '0;
		sel_pos   = '0;
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			id_hit[k]  = (CNT_W'(k) < cnt_q) && (chan_q[ord_q[k]] == r.chan_id);
			sel_hit[k] = (CNT_W'(k) < cnt_q) && free_q[ord_q[k]] && !asg_q[ord_q[k]];
		end
		for (int k = TABLE_DEPTH - 1; k >= 0; k--) begin
			if (id_hit[k]) begin
				id_found = 1'b1;
				id_pos   = IDX_W'(k);
			end
			if (sel_hit[k]) begin
				sel_found = 1'b1;
				sel_pos   = IDX_W'(k);
			end
		end
		id_slot  = ord_q[id_pos];
		sel_slot = ord_q[sel_pos];
	end

	always_comb begin
		ord_d      = ord_q;
		cnt_d      = cnt_q;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		ram_addr   = id_slot;
		ram_wdata  = {dst_m, src_m};
		f_we       = 1'b0;
		f_chan_we  = 1'b0;
		f_slot     = id_slot;
		f_free     = free_q[id_slot];
		f_asg      = asg_q[id_slot];
		st_d       = ST_UNCHANGED;
		asel_d     = AS_ZERO;
		held_chk_d = 1'b0;
		oc_d       = '0;
		of_d       = 1'b0;
		oa_d       = 1'b0;
		unique case (r.req_type)
			REQ_UPDATE: begin
				if (id_found) begin
					f_we   = 1'b1;
					f_free = r.free_flag;
					st_d   = ST_UPDATED;
					asel_d = AS_RAM;
					ram_re = 1'b1;
					oc_d   = r.chan_id;
					of_d   = r.free_flag;
					oa_d   = asg_q[id_slot];
				end else if (cnt_q == CNT_W'(TABLE_DEPTH)) begin
					st_d = ST_FULL;
				end else begin
					// Take the first unused slot and push it to the head
					f_slot    = ord_q[cnt_q[IDX_W-1:0]];
					f_we      = 1'b1;
					f_chan_we = 1'b1;
					f_free    = r.free_flag;
					f_asg     = 1'b0;
					ram_we    = 1'b1;
					ram_addr  = ord_q[cnt_q[IDX_W-1:0]];
					ram_wdata = '0;
					ord_d[0]  = ord_q[cnt_q[IDX_W-1:0]];
					for (int k = 1; k < TABLE_DEPTH; k++) begin
						if (CNT_W'(k) <= cnt_q) ord_d[k] = ord_q[k-1];
					end
					cnt_d  = cnt_q + 1'b1;
					st_d   = ST_INSERTED;
					oc_d   = r.chan_id;
					of_d   = r.free_flag;
				end
			end
			REQ_LOOKUP: begin
				if (id_found) begin
					st_d   = ST_FOUND;
					asel_d = AS_RAM;
					ram_re = 1'b1;
					oc_d   = r.chan_id;
					of_d   = free_q[id_slot];
					oa_d   = asg_q[id_slot];
				end else begin
					st_d = ST_NOTFOUND;
				end
			end
			REQ_DELETE: begin
				if (id_found) begin
					st_d   = ST_DELETED;
					asel_d = AS_RAM;
					ram_re = 1'b1;
					oc_d   = r.chan_id;
					of_d   = free_q[id_slot];
					oa_d   = asg_q[id_slot];
					// Close the gap, park the freed slot at the tail
					for (int k = 0; k < TABLE_DEPTH - 1; k++) begin
						if (IDX_W'(k) >= id_pos) ord_d[k] = ord_q[k+1];
					end
					ord_d[TABLE_DEPTH-1] = id_slot;
					cnt_d = cnt_q - 1'b1;
				end else begin
					st_d = ST_NOTFOUND;
				end
			end
			REQ_CLEAR: begin
				cnt_d = '0;
				st_d  = ST_CLEARED;
			end
			REQ_SETASG: begin
				if (!id_found) begin
					st_d = ST_NOTFOUND;
				end else begin
					oc_d = r.chan_id;
					of_d = free_q[id_slot];
					oa_d = asg_q[id_slot];
					if (!free_q[id_slot]) begin
						st_d   = ST_NOTFREE;
						asel_d = AS_RAM;
						ram_re = 1'b1;
					end else if (asg_q[id_slot] == r.assign_flag) begin
						st_d       = ST_UNCHANGED;
						held_chk_d = r.assign_flag;
						asel_d     = AS_RAM;
						ram_re     = 1'b1;
					end else begin
						st_d  = ST_ASSIGNED;
						f_we  = 1'b1;
						f_asg = r.assign_flag;
						oa_d  = r.assign_flag;
						if (r.assign_flag) begin
							ram_we = 1'b1;
							asel_d = AS_INPUT;
						end else begin
							ram_re = 1'b1;
							asel_d = AS_RAM;
						end
					end
				end
			end
			REQ_SELECT: begin
				if (sel_found) begin
					f_slot   = sel_slot;
					f_we     = 1'b1;
					f_free   = 1'b1;
					f_asg    = 1'b1;
					ram_we   = 1'b1;
					ram_addr = sel_slot;
					st_d     = ST_ASSIGNED;
					asel_d   = AS_INPUT;
					oc_d     = chan_q[sel_slot];
					of_d     = 1'b1;
					oa_d     = 1'b1;
				end else begin
					st_d = ST_NONEFREE;
				end
			end
			default: begin
				st_d = ST_UNCHANGED;
			end
		endcase
	end

	cat_ram #(.WIDTH(RAM_W), .DEPTH(TABLE_DEPTH)) u_addr_ram (
		.clk   (clk),
		.we    (acc && ram_we),
		.re    (acc && ram_re),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			for (int k = 0; k < TABLE_DEPTH; k++) ord_q[k] <= IDX_W'(k);
		end else if (acc) begin
			cnt_q <= cnt_d;
			ord_q <= ord_d;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && f_we) begin
			free_q[f_slot] <= f_free;
			asg_q[f_slot]  <= f_asg;
			if (f_chan_we) chan_q[f_slot] <= r.chan_id;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			st_s1       <= st_d;
			asel_s1     <= asel_d;
			held_chk_s1 <= held_chk_d;
			oc_s1       <= oc_d;
			of_s1       <= of_d;
			oa_s1       <= oa_d;
			src_s1      <= src_m;
			dst_s1      <= dst_m;
		end
	end

	always_comb begin
		unique case (asel_s1)
			AS_RAM: begin
				o_src = ram_rdata[ADDR_BITS-1:0];
				o_dst = ram_rdata[RAM_W-1:ADDR_BITS];
			end
			AS_INPUT: begin
				o_src = src_s1;
				o_dst = dst_s1;
			end
			default: begin
				o_src = '0;
				o_dst = '0;
			end
		endcase
		st_fin = (held_chk_s1 && (ram_rdata[ADDR_BITS-1:0] != src_s1)) ? ST_HELD : st_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			pend_s1 <= acc;
			if (pend_s1) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_s1) begin
			out_q.status       <= st_fin;
			out_q.out_chan_id  <= oc_s1;
			out_q.out_free     <= of_s1;
			out_q.out_assigned <= oa_s1;
			out_q.out_src_addr <= 64'(o_src);
			out_q.out_dst_addr <= 64'(o_dst);
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count beyond table depth");
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		!(pend_s1 && out_valid_q))
		else $error("two requests in flight");
	a_pend_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |=> out_valid_q)
		else $error("response word not presented");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> !req.ready)
		else $error("accepted while busy");

endmodule

`default_nettype wire

@@ rtl/core/cat_ram.sv @@
// ----------------------------------------------------------------------------
// cat_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module cat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end else if (re) begin
			rdata <= mem_q[addr];
		end
	end
endmodule

`default_nettype wire
